@@ rtl/usm_pkg.sv @@
// Shared types and constants for the unique set with maximum tracking.
// Used by usm_ctrl, usm_dp and unique_set_with_max_core; no dependencies.
`default_nettype none

package usm_pkg;

    // Table depth and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    // Widths of the result beat fields
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_ERASE  = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic start;       // capture the input beat and clear the sweep
        logic scan;        // walk the table looking for a match
        logic shift_init;  // point the sweep just past the matched slot
        logic shift;       // move later entries down by one slot
        logic commit;      // update count, maximum and result
        logic load_out;    // copy the result into the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic sweep_done;  // pointer reached the fill count and pipe is empty
        logic need_shift;  // erase hit a slot that has entries above it
    } t_dp_stat;

endpackage

`default_nettype wire

@@ rtl/usm_dp.sv @@
// Datapath: slot memory, sweep pointer, match and maximum tracking, result
// and output registers. Depends on usm_pkg; driven by usm_ctrl commands.
`default_nettype none

module usm_dp (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  usm_pkg::t_dp_cmd             i_cmd,
    output usm_pkg::t_dp_stat            o_stat,
    input  wire                          i_command,
    input  wire signed [31:0]            i_value,
    output logic [usm_pkg::STATUS_W-1:0] o_out_status,
    output logic [usm_pkg::POS_W-1:0]    o_out_position,
    output logic [usm_pkg::COUNT_W-1:0]  o_out_element_count,
    output logic                         o_out_max_valid,
    output logic signed [31:0]           o_out_max_value
);
    import usm_pkg::*;

    // Slot memory
    logic [DATA_W-1:0] mem [CAPACITY];

    // Beat being worked on
    logic                     r_cmd;
    logic signed [DATA_W-1:0] r_value;

    // Persistent set state
    logic [CNT_W-1:0]         r_fill;
    logic signed [DATA_W-1:0] r_largest;
    logic                     r_largest_vld;

    // Sweep pipeline
    logic [CNT_W-1:0]         r_ptr;
    logic                     r_dv;
    logic [IDX_W-1:0]         r_dv_idx;
    logic signed [DATA_W-1:0] r_rd_data;

    // Scan results
    logic                     r_hit;
    logic [IDX_W-1:0]         r_hit_idx;
    logic signed [DATA_W-1:0] r_omax;
    logic                     r_omax_vld;

    // Result of the committed command
    logic [STATUS_W-1:0]      r_res_status;
    logic [IDX_W-1:0]         r_res_pos;

    // Output register
    logic [STATUS_W-1:0]      r_out_status;
    logic [POS_W-1:0]         r_out_pos;
    logic [COUNT_W-1:0]       r_out_count;
    logic                     r_out_max_vld;
    logic signed [DATA_W-1:0] r_out_max;

    logic                     rd_en;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic [DATA_W-1:0]        wr_data;
    logic                     can_insert;

    // Issue a read while the pointer is below the fill count
    assign rd_en = (i_cmd.scan || i_cmd.shift) && (r_ptr < r_fill);

    assign can_insert = (r_cmd == CMD_INSERT) && !r_hit && (r_fill < CNT_W'(CAPACITY));

    // Select the write: shift moves data down, commit appends on insert
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_fill[IDX_W-1:0];
        wr_data = r_value;
        if (i_cmd.shift && r_dv) begin
            wr_en   = 1'b1;
            wr_addr = r_dv_idx - IDX_W'(1);
            wr_data = r_rd_data;
        end else if (i_cmd.commit && can_insert) begin
            wr_en   = 1'b1;
            wr_addr = r_fill[IDX_W-1:0];
            wr_data = r_value;
        end
    end

    // Memory write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_ptr[IDX_W-1:0]];
        end
    end

    // Sweep pointer, match and running maximum of non-matching entries
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cmd      <= i_command;
            r_value    <= i_value;
            r_ptr      <= '0;
            r_dv       <= 1'b0;
            r_hit      <= 1'b0;
            r_hit_idx  <= '0;
            r_omax_vld <= 1'b0;
        end else if (i_cmd.shift_init) begin
            r_ptr <= CNT_W'(r_hit_idx) + CNT_W'(1);
            r_dv  <= 1'b0;
        end else if (i_cmd.scan || i_cmd.shift) begin
            r_dv     <= rd_en;
            r_dv_idx <= r_ptr[IDX_W-1:0];
            if (rd_en) begin
                r_ptr <= r_ptr + CNT_W'(1);
            end
            if (i_cmd.scan && r_dv) begin
                if (r_rd_data == r_value) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_dv_idx;
                end else if (!r_omax_vld || (r_rd_data > r_omax)) begin
                    r_omax     <= r_rd_data;
                    r_omax_vld <= 1'b1;
                end
            end
        end
    end

    // Commit the command to the set state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill        <= '0;
            r_largest     <= '0;
            r_largest_vld <= 1'b0;
        end else if (i_cmd.commit) begin
            r_res_status <= ST_REJECT;
            r_res_pos    <= '0;
            if (r_cmd == CMD_INSERT) begin
                if (r_hit) begin
                    r_res_status <= ST_REJECT;
                end else if (!can_insert) begin
                    r_res_status <= ST_FULL;
                end else begin
                    r_res_status <= ST_DONE;
                    r_res_pos    <= r_fill[IDX_W-1:0];
                    r_fill       <= r_fill + CNT_W'(1);
                    if (!r_largest_vld || (r_value > r_largest)) begin
                        r_largest     <= r_value;
                        r_largest_vld <= 1'b1;
                    end
                end
            end else if (r_hit) begin
                r_res_status <= ST_DONE;
                r_res_pos    <= r_hit_idx;
                r_fill       <= r_fill - CNT_W'(1);
                if (r_fill == CNT_W'(1)) begin
                    r_largest     <= '0;
                    r_largest_vld <= 1'b0;
                end else if (r_largest_vld && (r_value == r_largest)) begin
                    r_largest     <= r_omax;
                    r_largest_vld <= 1'b1;
                end
            end
        end
    end

    // Load the output beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status  <= r_res_status;
            r_out_pos     <= POS_W'(r_res_pos);
            r_out_count   <= COUNT_W'(r_fill);
            r_out_max_vld <= r_largest_vld;
            r_out_max     <= r_largest_vld ? r_largest : '0;
        end
    end

    assign o_stat.sweep_done = (r_ptr == r_fill) && !r_dv;
    assign o_stat.need_shift = (r_cmd == CMD_ERASE) && r_hit &&
                               ((CNT_W'(r_hit_idx) + CNT_W'(1)) < r_fill);

    assign o_out_status        = r_out_status;
    assign o_out_position      = r_out_pos;
    assign o_out_element_count = r_out_count;
    assign o_out_max_valid     = r_out_max_vld;
    assign o_out_max_value     = r_out_max;

endmodule

`default_nettype wire

@@ rtl/usm_ctrl.sv @@
// Controller: sequences accept, scan, shift, commit and output hand-off.
// Depends on usm_pkg; drives usm_dp through t_dp_cmd.
`default_nettype none

module usm_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output usm_pkg::t_dp_cmd   o_cmd,
    input  usm_pkg::t_dp_stat  i_stat
);
    import usm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_COMMIT,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    // Output register can take a new beat when empty or being drained
    assign out_free = !r_out_valid || !i_out_stall;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.sweep_done) begin
                    if (i_stat.need_shift) begin
                        o_cmd.shift_init = 1'b1;
                        n_state          = S_SHIFT;
                    end else begin
                        n_state = S_COMMIT;
                    end
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_stat.sweep_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and the output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ rtl/unique_set_with_max_core.sv @@
// Unique set with maximum tracking: up to CAPACITY distinct signed values.
// Each beat is handled in turn: the single read port of the slot memory walks
// one entry per cycle for the match scan and again for the erase shift-down,
// then the result is committed and loaded into the output register.
// A new beat is taken only after the last result is loaded; it is taken while that result waits.
// Reset: synchronous active-low; clears count and maximum, slots are not cleared.
`default_nettype none

module unique_set_with_max_core (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire                          i_command,
    input  wire signed [31:0]            i_value,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [usm_pkg::STATUS_W-1:0] o_out_status,
    output logic [usm_pkg::POS_W-1:0]    o_out_position,
    output logic [usm_pkg::COUNT_W-1:0]  o_out_element_count,
    output logic                         o_out_max_valid,
    output logic signed [31:0]           o_out_max_value
);
    import usm_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    usm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    usm_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (dp_cmd),
        .o_stat              (dp_stat),
        .i_command           (i_command),
        .i_value             (i_value),
        .o_out_status        (o_out_status),
        .o_out_position      (o_out_position),
        .o_out_element_count (o_out_element_count),
        .o_out_max_valid     (o_out_max_valid),
        .o_out_max_value     (o_out_max_value)
    );

`ifndef SYNTH
    // A taken beat keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block not busy after accepting a beat");

    // Maximum is valid exactly when the set holds elements
    a_max_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_max_valid == (o_out_element_count != '0)))
        else $error("max_valid disagrees with element count");

    // Full status only with a full table
    a_full_at_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_status == ST_FULL)) |->
            (o_out_element_count == COUNT_W'(CAPACITY)))
        else $error("full status with room left");

    // Rejected or full commands report position zero
    a_pos_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_status != ST_DONE)) |-> (o_out_position == '0))
        else $error("nonzero position on a failed command");
`endif

endmodule

`default_nettype wire
